/* rtl/itce_pkg.sv */
// Shared types and constants for the IPv4/TCP checksum engine.
`default_nettype none

package itce_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_TRUNCATED     = 2'd1,
    STATUS_LEN_BELOW_HDR = 2'd2
  } status_t;

  // One finished result word
  typedef struct packed {
    logic [15:0] ip_header_checksum;
    logic [15:0] tcp_segment_checksum;
    status_t     status;
  } itce_result_t;

  // Header sum start value
  localparam logic [15:0] HDR_INIT = 16'hffff;
  // Bytes per unit of the IHL field
  localparam logic [5:0]  IHL_UNIT = 6'd4;
  // Offset of the TCP check field inside the segment
  localparam logic [6:0]  CHECK_OFF = 7'd16;
  // Saturation value of the byte counter
  localparam logic [15:0] INDEX_MAX = 16'hffff;

endpackage

`default_nettype wire

/* rtl/itce_pkt_if.sv */
// Packet byte stream channel: one byte and a last flag per word.
`default_nettype none

interface itce_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

/* rtl/itce_res_if.sv */
// Result channel: both checksums and a status per word.
`default_nettype none

interface itce_res_if
  import itce_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [15:0] ip_header_checksum;
  logic [15:0] tcp_segment_checksum;
  status_t     status;

  modport source (output valid, output ip_header_checksum, output tcp_segment_checksum,
                  output status, input ready);
  modport sink   (input valid, input ip_header_checksum, input tcp_segment_checksum,
                  input status, output ready);
endinterface

`default_nettype wire

/* rtl/itce_acc.sv */
// Per-byte checksum accumulator: header fields, running sums and the final result.
`default_nettype none

module itce_acc
  import itce_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         last,
  output itce_result_t result
);

  // Fixed header offsets
  localparam logic [15:0] OFS_IHL     = 16'd0;
  localparam logic [15:0] OFS_TLEN_HI = 16'd2;
  localparam logic [15:0] OFS_TLEN_LO = 16'd3;
  localparam logic [15:0] OFS_PROTO   = 16'd9;
  localparam logic [15:0] OFS_CSUM_HI = 16'd10;
  localparam logic [15:0] OFS_CSUM_LO = 16'd11;
  localparam logic [15:0] OFS_ADDR_LO = 16'd13;
  localparam logic [15:0] OFS_ADDR_HI = 16'd19;
  localparam logic [15:0] OFS_MIN_LEN = 16'd3;

  // Ones'-complement add with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[15:0]} + {16'd0, s[16]};
    return f[15:0];
  endfunction

  logic [15:0] byte_index;
  logic [5:0]  header_bytes;
  logic [15:0] total_length;
  logic [7:0]  held_high_byte;
  logic [15:0] header_sum;
  logic [15:0] segment_sum;
  logic        length_error;

  logic [5:0]  hb_cur;
  logic [15:0] tl_cur;
  logic        le_cur;
  logic [6:0]  chk;
  logic        odd;
  logic [15:0] word;
  logic [15:0] hi_word;
  logic        lt_hb;
  logic        in_seg;
  logic        seg_tail;
  logic [15:0] hdr_add;
  logic [15:0] seg_add;
  logic [15:0] extra_add;
  logic [15:0] header_sum_next;
  logic [15:0] seg_sum_mid;
  logic [15:0] segment_sum_next;
  logic [15:0] tcp_len;
  logic [15:0] index_m1;
  logic [16:0] index_p1;

  // Header fields as seen by this byte
  always_comb begin
    hb_cur = header_bytes;
    tl_cur = total_length;
    le_cur = length_error;
    if (byte_index == OFS_IHL) begin
      hb_cur = {2'b00, data_byte[3:0]} * IHL_UNIT;
    end else if (byte_index == OFS_TLEN_HI) begin
      tl_cur = {data_byte, 8'h00};
    end else if (byte_index == OFS_TLEN_LO) begin
      tl_cur = {total_length[15:8], data_byte};
      le_cur = (tl_cur < {10'd0, hb_cur});
    end
  end

  assign chk      = {1'b0, hb_cur} + CHECK_OFF;
  assign odd      = byte_index[0];
  assign word     = {held_high_byte, data_byte};
  assign hi_word  = {data_byte, 8'h00};
  assign index_m1 = byte_index - 16'd1;
  assign index_p1 = {1'b0, byte_index} + 17'd1;
  assign lt_hb    = byte_index < {10'd0, hb_cur};
  assign in_seg   = (byte_index >= {10'd0, hb_cur}) &&
                    ((byte_index < 16'd4) || (byte_index < tl_cur));
  assign seg_tail = last || (index_p1 == {1'b0, tl_cur});

  // Select the words that join each sum
  always_comb begin
    hdr_add   = 16'h0000;
    seg_add   = 16'h0000;
    extra_add = 16'h0000;
    if (odd) begin
      if (lt_hb && (byte_index != OFS_CSUM_LO)) hdr_add = word;
      if (in_seg && (index_m1 != {9'd0, chk})) seg_add = word;
      if ((byte_index >= OFS_ADDR_LO) && (byte_index <= OFS_ADDR_HI)) extra_add = word;
    end else begin
      if (lt_hb && last && (byte_index != OFS_CSUM_HI)) hdr_add = hi_word;
      if (in_seg && (byte_index != {9'd0, chk}) && seg_tail) seg_add = hi_word;
    end
    if (byte_index == OFS_PROTO) extra_add = {8'h00, data_byte};
  end

  assign header_sum_next  = oc_add(header_sum, hdr_add);
  assign seg_sum_mid      = oc_add(segment_sum, seg_add);
  assign segment_sum_next = oc_add(seg_sum_mid, extra_add);
  assign tcp_len          = tl_cur - {10'd0, hb_cur};

  // Form the result for a last byte
  always_comb begin
    result.ip_header_checksum   = ~header_sum_next;
    result.tcp_segment_checksum = ~oc_add(segment_sum_next, tcp_len);
    if (byte_index < OFS_MIN_LEN) begin
      result.status = STATUS_TRUNCATED;
    end else if (le_cur) begin
      result.status = STATUS_LEN_BELOW_HDR;
    end else if (index_p1 < {1'b0, tl_cur}) begin
      result.status = STATUS_TRUNCATED;
    end else begin
      result.status = STATUS_OK;
    end
  end

  // Advance state; clear it on reset or after the last byte
  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      byte_index     <= 16'd0;
      header_bytes   <= 6'd0;
      total_length   <= 16'd0;
      held_high_byte <= 8'd0;
      header_sum     <= HDR_INIT;
      segment_sum    <= 16'd0;
      length_error   <= 1'b0;
    end else if (step) begin
      byte_index   <= (byte_index == INDEX_MAX) ? byte_index : index_p1[15:0];
      header_bytes <= hb_cur;
      total_length <= tl_cur;
      length_error <= le_cur;
      header_sum   <= header_sum_next;
      segment_sum  <= segment_sum_next;
      if (!odd) held_high_byte <= data_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/ipv4_tcp_checksum_engine.sv */
// Top level of the IPv4 header and TCP segment checksum engine.
//
// The pkt channel carries one packet byte per word in wire order, starting
// at the IPv4 version byte, with last set on the final byte. The res channel
// carries one word per packet: the IPv4 header checksum, the TCP checksum
// over pseudo-header and segment, and a status (ok, truncated, or total
// length below the header length). Bytes past the total length are ignored.
//
// Throughput is one byte per cycle while no last byte waits on a stalled res.
// A byte is registered at acceptance and folded into the running sums as it
// leaves the input register; a last byte also loads the result register then,
// and res shows the result from that register until it is taken.
// When res stalls, bytes of the following packet keep flowing; only that
// packet's last byte waits in the input register until the held result is
// taken, and pkt.ready drops behind it.
// Reset (rst, synchronous) empties both registers and clears the sums.
`default_nettype none

module ipv4_tcp_checksum_engine
  import itce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  itce_pkt_if.sink   pkt,
  itce_res_if.source res
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic         s1_advance;
  logic         out_valid;
  itce_result_t out_result;
  itce_result_t acc_result;

  // A last byte needs room in the result register
  assign s1_advance = s1_valid && (!s1_last || !out_valid || res.ready);
  assign pkt.ready  = !s1_valid || s1_advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pkt.valid && pkt.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      s1_byte <= pkt.data_byte;
      s1_last <= pkt.last;
    end
  end

  itce_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .step      (s1_advance),
    .data_byte (s1_byte),
    .last      (s1_last),
    .result    (acc_result)
  );

  // Result register: load on a last byte, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      out_result <= acc_result;
    end
  end

  assign res.valid                = out_valid;
  assign res.ip_header_checksum   = out_result.ip_header_checksum;
  assign res.tcp_segment_checksum = out_result.tcp_segment_checksum;
  assign res.status               = out_result.status;

  // A result appears only after a last byte was folded in
  a_res_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("result raised without a last byte");

  // A stalled result blocks a waiting last byte
  a_last_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && out_valid && !res.ready) |-> !pkt.ready)
    else $error("input accepted while last byte blocked");

  // A byte that cannot advance stays in the input register
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> (s1_valid && $stable(s1_byte) && $stable(s1_last)))
    else $error("input register lost a byte");

endmodule

`default_nettype wire
